FILE: rtl/epl_pkg.sv
// Shared types, constants and microcode encodings of the energy PD power limiter.
// No dependencies; imported by every module of the block.
package epl_pkg;

    localparam int EnergyW  = 24;
    localparam int GainW    = 16;
    localparam int PowW     = 18;
    localparam int LimW     = 19;
    localparam int TickW    = 16;
    localparam int ErrW     = 25;
    localparam int DvdW     = 42;
    localparam int ProdW    = 42;
    localparam int AccW     = 59;
    localparam int PdW      = 22;
    localparam int DivSteps = 21;
    localparam int CntW     = 5;
    localparam int PcW      = 4;
    localparam int AddrW    = 5;
    localparam int DataW    = 32;

    localparam logic [PowW-1:0] NOMINAL_RESET = 18'd20480;
    localparam logic [PowW-1:0] FLOOR_RESET   = 18'd7680;
    localparam logic [LimW-1:0] LIM_MAX       = 19'd393215;

    typedef enum logic [2:0] {
        REG_TARGET  = 3'd0,
        REG_KP      = 3'd1,
        REG_KD      = 3'd2,
        REG_NOMINAL = 3'd3,
        REG_FLOOR   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [EnergyW-1:0] measured_energy;
        logic [TickW-1:0]   elapsed_ticks;
    } t_in_item;

    typedef struct packed {
        logic [LimW-1:0] upper_limit;
        logic [LimW-1:0] lower_limit;
    } t_out_item;

    typedef struct packed {
        logic [EnergyW-1:0] energy_target;
        logic [GainW-1:0]   prop_gain;
        logic [GainW-1:0]   deriv_gain;
        logic [PowW-1:0]    nominal_power;
        logic [PowW-1:0]    power_floor;
    } t_cfg;

    typedef logic [PcW-1:0] t_pc;

    typedef enum logic [2:0] {
        DP_NOP  = 3'd0,
        DP_LOAD = 3'd1,
        DP_DIFF = 3'd2,
        DP_DIV  = 3'd3,
        DP_SIGN = 3'd4,
        DP_PD   = 3'd5,
        DP_LIM  = 3'd6,
        DP_OUT  = 3'd7
    } t_dp_op;

    typedef enum logic [1:0] {
        MUL_NONE   = 2'd0,
        MUL_KP_ERR = 2'd1,
        MUL_KD_LO  = 2'd2,
        MUL_KD_HI  = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD   = 2'd1,
        ACC_ADD    = 2'd2,
        ACC_ADD_HI = 2'd3
    } t_acc_op;

    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_WAIT_IN  = 3'd1,
        JC_SKIP_ZT  = 3'd2,
        JC_LOOP     = 3'd3,
        JC_WAIT_OUT = 3'd4
    } t_jmp;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel mul;
        t_acc_op  acc;
        t_jmp     jmp;
        t_pc      target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic zero_dt;
        logic div_last;
        logic out_free;
    } t_useq_stat;

    localparam t_pc PC_IDLE = 4'd0;
    localparam t_pc PC_DIFF = 4'd1;
    localparam t_pc PC_DIV  = 4'd2;
    localparam t_pc PC_SIGN = 4'd3;
    localparam t_pc PC_MLO  = 4'd4;
    localparam t_pc PC_MHI  = 4'd5;
    localparam t_pc PC_ACC  = 4'd6;
    localparam t_pc PC_PD   = 4'd7;
    localparam t_pc PC_LIM  = 4'd8;
    localparam t_pc PC_OUT  = 4'd9;

endpackage

FILE: rtl/epl_regs.sv
// APB-style configuration register file of the energy PD power limiter.
// Depends on epl_pkg for register indexes and the configuration struct.
module epl_regs
    import epl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.energy_target <= '0;
            r_cfg.prop_gain     <= '0;
            r_cfg.deriv_gain    <= '0;
            r_cfg.nominal_power <= NOMINAL_RESET;
            r_cfg.power_floor   <= FLOOR_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_TARGET:  r_cfg.energy_target <= pwdata[EnergyW-1:0];
                REG_KP:      r_cfg.prop_gain     <= pwdata[GainW-1:0];
                REG_KD:      r_cfg.deriv_gain    <= pwdata[GainW-1:0];
                REG_NOMINAL: r_cfg.nominal_power <= pwdata[PowW-1:0];
                REG_FLOOR:   r_cfg.power_floor   <= pwdata[PowW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TARGET:  prdata = {{(DataW-EnergyW){1'b0}}, r_cfg.energy_target};
            REG_KP:      prdata = {{(DataW-GainW){1'b0}}, r_cfg.prop_gain};
            REG_KD:      prdata = {{(DataW-GainW){1'b0}}, r_cfg.deriv_gain};
            REG_NOMINAL: prdata = {{(DataW-PowW){1'b0}}, r_cfg.nominal_power};
            REG_FLOOR:   prdata = {{(DataW-PowW){1'b0}}, r_cfg.power_floor};
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: rtl/epl_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on epl_pkg for the control word, status struct and step addresses.
module epl_useq
    import epl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_useq_stat i_stat,
    output t_uword     o_uword
);

    t_pc r_pc;
    t_pc n_pc;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: DP_NOP, mul: MUL_NONE, acc: ACC_HOLD, jmp: JC_NEXT, target: PC_IDLE};
        unique case (pc)
            PC_IDLE: begin
                w.op  = DP_LOAD;
                w.jmp = JC_WAIT_IN;
            end
            PC_DIFF: begin
                w.op     = DP_DIFF;
                w.jmp    = JC_SKIP_ZT;
                w.target = PC_SIGN;
            end
            PC_DIV: begin
                w.op  = DP_DIV;
                w.jmp = JC_LOOP;
            end
            PC_SIGN: begin
                w.op  = DP_SIGN;
                w.mul = MUL_KP_ERR;
            end
            PC_MLO: begin
                w.mul = MUL_KD_LO;
                w.acc = ACC_LOAD;
            end
            PC_MHI: begin
                w.mul = MUL_KD_HI;
                w.acc = ACC_ADD;
            end
            PC_ACC: begin
                w.acc = ACC_ADD_HI;
            end
            PC_PD: begin
                w.op = DP_PD;
            end
            PC_LIM: begin
                w.op = DP_LIM;
            end
            PC_OUT: begin
                w.op     = DP_OUT;
                w.jmp    = JC_WAIT_OUT;
                w.target = PC_IDLE;
            end
            default: begin
                w.target = PC_IDLE;
                w.jmp    = JC_WAIT_OUT;
            end
        endcase
        return w;
    endfunction

    assign o_uword = ucode(r_pc);

    always_comb begin
        unique case (o_uword.jmp)
            JC_NEXT:     n_pc = r_pc + 1'b1;
            JC_WAIT_IN:  n_pc = i_stat.in_valid ? r_pc + 1'b1 : r_pc;
            JC_SKIP_ZT:  n_pc = i_stat.zero_dt ? o_uword.target : r_pc + 1'b1;
            JC_LOOP:     n_pc = i_stat.div_last ? r_pc + 1'b1 : r_pc;
            JC_WAIT_OUT: n_pc = i_stat.out_free ? o_uword.target : r_pc;
            default:     n_pc = PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: rtl/energy_pd_power_limiter_top.sv
// Top level of the energy PD power limiter: datapath driven by the microcode sequencer.
// Depends on epl_pkg, epl_regs and epl_useq.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------
//  in      | request   | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | result    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//  cfg     | APB write | psel penable pwrite pready | paddr pwdata -> prdata
//
// A request passes the difference, divider, sign, multiply, accumulate, PD and limit steps
// to the output register; the radix-4 divider loop (21 steps) is skipped for zero elapsed time.
// A new request is accepted once the previous result sits in the output register.
// The output register holds its result while i_out_ready is low; the sequencer
// waits at its last step only if a second result is ready before the first is taken.
// Reset (synchronous, active low) restores register defaults and clears the error history.
module energy_pd_power_limiter_top
    import epl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    t_cfg       cfg;
    t_uword     uw;
    t_useq_stat stat;

    logic signed [ErrW-1:0]  r_err;
    logic signed [ErrW-1:0]  r_last_err;
    logic [TickW-1:0]        r_ticks;
    logic [DvdW-1:0]         r_dvd;
    logic [TickW-1:0]        r_rem;
    logic                    r_neg;
    logic [CntW-1:0]         r_cnt;
    logic signed [ProdW-1:0] r_prod;
    logic signed [AccW-1:0]  r_acc;
    logic signed [PdW-1:0]   r_pd;
    logic [LimW-1:0]         r_upper;
    logic [LimW-1:0]         r_lower;
    logic [LimW-1:0]         r_held;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    fire_load;
    logic                    out_free;
    logic signed [ErrW:0]    diff;
    logic [ErrW:0]           diff_mag;
    logic [TickW:0]          t1, t2, r1, r2;
    logic                    ge1, ge2;
    logic signed [GainW:0]   mul_a;
    logic signed [ErrW-1:0]  mul_b;
    logic signed [ProdW-1:0] mul_p;
    logic signed [AccW-1:0]  prod_ext;
    logic signed [AccW-1:0]  biased;
    logic signed [AccW-9:0]  pd_full;
    logic signed [PdW-1:0]   pd_sat;
    logic signed [LimW+3:0]  nom_s, pd_s, held_s, ceil_s, floor_s, max_s;
    logic signed [LimW+3:0]  up0, up1, up2, lo0, lo1, lo2;

    localparam logic signed [AccW-9:0] PdPos = (AccW-8)'(1 << 20);
    localparam logic signed [AccW-9:0] PdNeg = -PdPos;

    epl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    epl_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_in_ready    = (uw.jmp == JC_WAIT_IN);
    assign fire_load     = o_in_ready && i_in_valid;
    assign stat.in_valid = i_in_valid;
    assign stat.zero_dt  = (r_ticks == '0);
    assign stat.div_last = (r_cnt == CntW'(DivSteps - 1));
    assign stat.out_free = out_free;
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out;

    // error difference and its magnitude
    assign diff     = {r_err[ErrW-1], r_err} - {r_last_err[ErrW-1], r_last_err};
    assign diff_mag = diff[ErrW] ? ErrW'(1'b0) - diff : diff;

    // two restoring division steps per cycle
    assign t1  = {r_rem, r_dvd[DvdW-1]};
    assign ge1 = (t1 >= {1'b0, r_ticks});
    assign r1  = ge1 ? t1 - {1'b0, r_ticks} : t1;
    assign t2  = {r1[TickW-1:0], r_dvd[DvdW-2]};
    assign ge2 = (t2 >= {1'b0, r_ticks});
    assign r2  = ge2 ? t2 - {1'b0, r_ticks} : t2;

    // shared multiplier, derivative split into 21-bit halves
    always_comb begin
        case (uw.mul)
            MUL_KP_ERR: begin
                mul_a = {1'b0, cfg.prop_gain};
                mul_b = r_err;
            end
            MUL_KD_LO: begin
                mul_a = {1'b0, cfg.deriv_gain};
                mul_b = {4'b0, r_dvd[20:0]};
            end
            MUL_KD_HI: begin
                mul_a = {1'b0, cfg.deriv_gain};
                mul_b = {{4{r_dvd[DvdW-1]}}, r_dvd[DvdW-1:21]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{(AccW-ProdW){r_prod[ProdW-1]}}, r_prod};

    // truncate toward zero, then saturate
    assign biased  = r_acc + (r_acc[AccW-1] ? AccW'(255) : AccW'(0));
    assign pd_full = biased[AccW-1:8];
    assign pd_sat  = (pd_full > PdPos) ? PdW'(PdPos) :
                     (pd_full < PdNeg) ? PdW'(PdNeg) : pd_full[PdW-1:0];

    assign nom_s   = {5'b0, cfg.nominal_power};
    assign pd_s    = {r_pd[PdW-1], r_pd};
    assign held_s  = {4'b0, r_held};
    assign ceil_s  = {5'b0, cfg.nominal_power} + {6'b0, cfg.nominal_power[PowW-1:1]};
    assign floor_s = {5'b0, cfg.power_floor};
    assign max_s   = {4'b0, LIM_MAX};

    assign up0 = nom_s + pd_s;
    assign up1 = (up0 < held_s) ? held_s : up0;
    assign up2 = (up1 > ceil_s) ? ceil_s : up1;
    assign lo0 = nom_s - pd_s;
    assign lo1 = (lo0 < floor_s) ? floor_s : lo0;
    assign lo2 = (lo1 > max_s) ? max_s : lo1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err  <= '0;
            r_held      <= {1'b0, FLOOR_RESET};
            r_out_valid <= 1'b0;
        end else begin
            if (uw.op == DP_DIFF) begin
                r_last_err <= r_err;
            end
            if (uw.op == DP_LIM) begin
                r_held <= lo2[LimW-1:0];
            end
            if (uw.op == DP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_load) begin
            r_err   <= $signed({1'b0, cfg.energy_target} - {1'b0, i_in_data.measured_energy});
            r_ticks <= i_in_data.elapsed_ticks;
        end
        case (uw.op)
            DP_DIFF: begin
                r_dvd <= stat.zero_dt ? '0 : {diff_mag, 16'b0};
                r_neg <= diff[ErrW];
                r_rem <= '0;
                r_cnt <= '0;
            end
            DP_DIV: begin
                r_dvd <= {r_dvd[DvdW-3:0], ge1, ge2};
                r_rem <= r2[TickW-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            DP_SIGN: begin
                r_dvd <= r_neg ? DvdW'(1'b0) - r_dvd : r_dvd;
            end
            DP_PD: begin
                r_pd <= pd_sat;
            end
            DP_LIM: begin
                r_upper <= up2[LimW-1:0];
                r_lower <= lo2[LimW-1:0];
            end
            DP_OUT: begin
                if (out_free) begin
                    r_out.upper_limit <= r_upper;
                    r_out.lower_limit <= r_lower;
                end
            end
            default: ;
        endcase
        if (uw.mul != MUL_NONE) begin
            r_prod <= mul_p;
        end
        case (uw.acc)
            ACC_LOAD:   r_acc <= prod_ext;
            ACC_ADD:    r_acc <= r_acc + prod_ext;
            ACC_ADD_HI: r_acc <= r_acc + {r_prod[37:0], 21'b0};
            default: ;
        endcase
    end

endmodule
